// ===== rtl/base64_text_decoder_assert.svh =====
// assertion macros for the base64 text decoder
// expects clk_i and rst_ni in the scope of every use
`ifndef BASE64_TEXT_DECODER_ASSERT_SVH
`define BASE64_TEXT_DECODER_ASSERT_SVH

`ifndef SYNTH

// property must hold at every rising clock edge outside reset
`define B64D_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("b64d: property violated");

// condition must never be true outside reset
`define B64D_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("b64d: forbidden condition seen");

`else

`define B64D_ASSERT(lbl, prop)
`define B64D_NEVER(lbl, cond)

`endif

`endif

// ===== rtl/b64d_pkg.sv =====
// shared types, constants and the alphabet lookup of the base64 text decoder
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package b64d_pkg;

  localparam int unsigned CountWidthDef = 16;
  localparam int unsigned QueueDepthDef = 2;
  localparam int unsigned MaxWidth      = 16;
  localparam int unsigned ShownWidth    = 16;

  localparam logic [MaxWidth-1:0] MaxOutReset = 16'hFFFF;

  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [7:0] CharTab   = 8'h09;
  localparam logic [7:0] CharPlus  = 8'h2B;
  localparam logic [7:0] CharSlash = 8'h2F;

  localparam logic KindData = 1'b0;
  localparam logic KindEnd  = 1'b1;

  typedef enum logic [1:0] {
    CLS_BLANK  = 2'd0,
    CLS_SEXTET = 2'd1,
    CLS_OTHER  = 2'd2
  } char_class_e;

  // one classified character, front to back
  typedef struct packed {
    logic        start;
    char_class_e cls;
    logic [5:0]  sextet;
  } mid_item_t;

  // one result, back to output queue
  typedef struct packed {
    logic                  kind;
    logic [7:0]            data_byte;
    logic [ShownWidth-1:0] byte_count;
    logic                  truncated;
  } result_t;

  // alphabet lookup: class and sextet of one character
  function automatic mid_item_t classify(input logic [7:0] c, input logic start);
    mid_item_t r;
    r.start  = start;
    r.cls    = CLS_OTHER;
    r.sextet = 6'd0;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r.cls    = CLS_SEXTET;
      r.sextet = 6'(c - 8'h41);
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      r.cls    = CLS_SEXTET;
      r.sextet = 6'(c - 8'h61 + 8'd26);
    end else if (c >= 8'h30 && c <= 8'h39) begin
      r.cls    = CLS_SEXTET;
      r.sextet = 6'(c - 8'h30 + 8'd52);
    end else if (c == CharPlus) begin
      r.cls    = CLS_SEXTET;
      r.sextet = 6'd62;
    end else if (c == CharSlash) begin
      r.cls    = CLS_SEXTET;
      r.sextet = 6'd63;
    end else if (c == CharSpace || c == CharTab) begin
      r.cls    = CLS_BLANK;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/b64d_fifo.sv =====
// small first-in first-out queue in flip-flops, registered outputs
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module b64d_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic [WIDTH-1:0]      rdata_o,
  output logic                  empty_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(DEPTH);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntFull);
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // payload storage, no reset
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/b64d_front.sv =====
// front end: accepts characters and classifies them against the alphabet
// depends on b64d_pkg
`timescale 1ns / 1ps
`default_nettype none

module b64d_front (
  input  wire logic             push,
  output logic                  full,
  input  wire logic [7:0]       char_code_i,
  input  wire logic             start_text_i,
  input  wire logic             q_full_i,
  output logic                  q_push_o,
  output b64d_pkg::mid_item_t   q_item_o
);

  import b64d_pkg::*;

  assign full     = q_full_i;
  assign q_push_o = push && !q_full_i;
  assign q_item_o = classify(char_code_i, start_text_i);

endmodule

`default_nettype wire

// ===== rtl/b64d_back.sv =====
// back end: group assembly, end detection, byte limit and counting
// depends on b64d_pkg
`timescale 1ns / 1ps
`default_nettype none

module b64d_back #(
  parameter int unsigned COUNT_WIDTH = b64d_pkg::CountWidthDef
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  input  wire b64d_pkg::mid_item_t               in_item_i,
  output logic                                   in_pop_o,
  input  wire logic                              out_full_i,
  output logic                                   out_push_o,
  output b64d_pkg::result_t                      out_item_o,
  input  wire logic [b64d_pkg::MaxWidth-1:0]     max_out_bytes_i
);

  import b64d_pkg::*;

  localparam int unsigned CmpW = (COUNT_WIDTH > MaxWidth) ? COUNT_WIDTH : MaxWidth;
  localparam logic [CmpW-1:0] ShownMax = CmpW'({ShownWidth{1'b1}});

  logic [1:0]             pos_q, pos_d;
  logic [5:0]             held_q, held_d;
  logic                   skip_q, skip_d;
  logic                   ended_q, ended_d;
  logic [COUNT_WIDTH-1:0] cnt_q, cnt_d;
  logic                   drop_q, drop_d;

  logic                   take;
  logic [7:0]             byte_v;
  logic [CmpW-1:0]        cnt_cmp;
  logic [CmpW-1:0]        max_cmp;
  logic [CmpW-1:0]        shown_src;
  logic [ShownWidth-1:0]  shown;

  // a character is taken only when the output queue has room
  assign take     = in_valid_i && !out_full_i;
  assign in_pop_o = take;

  always_comb begin
    pos_d      = pos_q;
    held_d     = held_q;
    skip_d     = skip_q;
    ended_d    = ended_q;
    cnt_d      = cnt_q;
    drop_d     = drop_q;
    out_push_o = 1'b0;
    out_item_o = '0;
    byte_v     = '0;
    cnt_cmp    = '0;
    max_cmp    = CmpW'(max_out_bytes_i);
    shown_src  = '0;
    shown      = '0;

    if (take) begin
      // start of text clears per-text state first
      if (in_item_i.start) begin
        pos_d   = '0;
        held_d  = '0;
        skip_d  = 1'b1;
        ended_d = 1'b0;
        cnt_d   = '0;
        drop_d  = 1'b0;
      end

      cnt_cmp = CmpW'(cnt_d);

      if (ended_d) begin
        // ignored until next start
      end else if (skip_d && in_item_i.cls == CLS_BLANK) begin
        // leading blank skipped
      end else begin
        skip_d = 1'b0;
        if (in_item_i.cls != CLS_SEXTET) begin
          ended_d   = 1'b1;
          shown_src = (cnt_cmp > ShownMax) ? ShownMax : cnt_cmp;
          shown     = shown_src[ShownWidth-1:0];
          out_push_o            = 1'b1;
          out_item_o.kind       = KindEnd;
          out_item_o.data_byte  = '0;
          out_item_o.byte_count = shown;
          out_item_o.truncated  = drop_d;
        end else begin
          unique case (pos_d)
            2'd1:    byte_v = {held_d, in_item_i.sextet[5:4]};
            2'd2:    byte_v = {held_d[3:0], in_item_i.sextet[5:2]};
            2'd3:    byte_v = {held_d[1:0], in_item_i.sextet};
            default: byte_v = '0;
          endcase
          if (pos_d != 2'd0) begin
            if (cnt_cmp >= max_cmp) begin
              drop_d = 1'b1;
            end else begin
              if (cnt_d != '1) begin
                cnt_d = cnt_d + 1'b1;
              end
              cnt_cmp   = CmpW'(cnt_d);
              shown_src = (cnt_cmp > ShownMax) ? ShownMax : cnt_cmp;
              shown     = shown_src[ShownWidth-1:0];
              out_push_o            = 1'b1;
              out_item_o.kind       = KindData;
              out_item_o.data_byte  = byte_v;
              out_item_o.byte_count = shown;
              out_item_o.truncated  = drop_d;
            end
          end
          held_d = in_item_i.sextet;
          pos_d  = pos_d + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      held_q  <= '0;
      skip_q  <= 1'b1;
      ended_q <= 1'b0;
      cnt_q   <= '0;
      drop_q  <= 1'b0;
    end else begin
      pos_q   <= pos_d;
      held_q  <= held_d;
      skip_q  <= skip_d;
      ended_q <= ended_d;
      cnt_q   <= cnt_d;
      drop_q  <= drop_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/base64_text_decoder.sv =====
// top level of the base64 text decoder: front end, middle queue, back end, result queue
// depends on b64d_pkg, b64d_front, b64d_back, b64d_fifo and base64_text_decoder_assert.svh
`timescale 1ns / 1ps
`default_nettype none

// base64 text decoder, standard alphabet. one character is pushed per request,
// with start_text_i marking the first character of a new text. leading spaces and
// tabs are skipped; every alphabet character gives a sextet and the second, third
// and fourth characters of a group each complete one data byte. the first
// character outside the alphabet ('=', nul or anything else) ends the text and
// gives one end result carrying the byte count; a lone trailing character gives
// no byte, and later characters are ignored until the next start. bytes past
// max_out_bytes are dropped and flag truncated. the block takes one character
// per clock and delivers at most one result per clock, sustained, while the
// consumer keeps popping; the back end takes a character whenever the middle
// queue holds one and the result queue has room, decoding straight from the
// middle queue's head. an accepted character is registered in the middle queue
// and its result in the result queue, whose head drives the outputs. write the
// limit register only while no text is in flight. no clearing pass after reset.
module base64_text_decoder #(
  parameter int unsigned COUNT_WIDTH = b64d_pkg::CountWidthDef,
  parameter int unsigned QUEUE_DEPTH = b64d_pkg::QueueDepthDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // character side
  input  wire logic                          push,
  output logic                               full,
  input  wire logic [7:0]                    char_code_i,
  input  wire logic                          start_text_i,
  // result side
  output logic                               empty,
  input  wire logic                          pop,
  output logic                               kind_o,
  output logic [7:0]                         data_byte_o,
  output logic [b64d_pkg::ShownWidth-1:0]    byte_count_o,
  output logic                               truncated_o,
  // limit register
  input  wire logic                          cfg_we_i,
  input  wire logic [b64d_pkg::MaxWidth-1:0] cfg_wdata_i
);

  import b64d_pkg::*;

  localparam int unsigned MidW = $bits(mid_item_t);
  localparam int unsigned ResW = $bits(result_t);

  // limit register, reset to the full range
  logic [MaxWidth-1:0] max_q;

  // front to middle queue
  logic      mid_push, mid_full, mid_empty, mid_pop;
  mid_item_t mid_wr_item;
  logic [MidW-1:0] mid_rdata;
  mid_item_t mid_rd_item;

  // back to result queue
  logic      res_push, res_full;
  result_t   res_wr_item;
  logic [ResW-1:0] res_rdata;
  result_t   res_rd_item;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q <= MaxOutReset;
    end else if (cfg_we_i) begin
      max_q <= cfg_wdata_i;
    end
  end

  // classify each character as it is requested
  b64d_front u_front (
    .push         (push),
    .full         (full),
    .char_code_i  (char_code_i),
    .start_text_i (start_text_i),
    .q_full_i     (mid_full),
    .q_push_o     (mid_push),
    .q_item_o     (mid_wr_item)
  );

  // decouples classification from decoding
  b64d_fifo #(
    .WIDTH (MidW),
    .DEPTH (QUEUE_DEPTH)
  ) u_mid_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (mid_push),
    .wdata_i (mid_wr_item),
    .full_o  (mid_full),
    .pop_i   (mid_pop),
    .rdata_o (mid_rdata),
    .empty_o (mid_empty)
  );

  assign mid_rd_item = mid_item_t'(mid_rdata);

  // per-text decoding state lives here
  b64d_back #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (!mid_empty),
    .in_item_i       (mid_rd_item),
    .in_pop_o        (mid_pop),
    .out_full_i      (res_full),
    .out_push_o      (res_push),
    .out_item_o      (res_wr_item),
    .max_out_bytes_i (max_q)
  );

  // result queue lets the decoder run on while the consumer stalls, until it fills
  b64d_fifo #(
    .WIDTH (ResW),
    .DEPTH (QUEUE_DEPTH)
  ) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .wdata_i (res_wr_item),
    .full_o  (res_full),
    .pop_i   (pop),
    .rdata_o (res_rdata),
    .empty_o (empty)
  );

  assign res_rd_item  = result_t'(res_rdata);
  assign kind_o       = res_rd_item.kind;
  assign data_byte_o  = res_rd_item.data_byte;
  assign byte_count_o = res_rd_item.byte_count;
  assign truncated_o  = res_rd_item.truncated;

`include "base64_text_decoder_assert.svh"

  // back end only writes a result when the result queue has room
  `B64D_NEVER(a_res_push_full, res_push && res_full)
  // back end only takes from a non-empty middle queue
  `B64D_NEVER(a_mid_pop_empty, mid_pop && mid_empty)
  // a delivered data byte is counted and within the limit
  `B64D_ASSERT(a_data_within_limit, (!empty && kind_o == KindData) |-> (byte_count_o != '0 && byte_count_o <= max_q))
  // an end result carries a zero data byte
  `B64D_ASSERT(a_end_zero_byte, (!empty && kind_o == KindEnd) |-> (data_byte_o == '0))

endmodule

`default_nettype wire

// ===== tb/tb_base64_text_decoder.sv =====
// self-checking testbench for the base64 text decoder top level
// depends on b64d_pkg and on the rtl of base64_text_decoder
`timescale 1ns / 1ps

// the character side pushes directed and random texts and random byte noise
// under a range of byte limits. an in-bench decode tracker follows every
// accepted request and queues the result it should cause; the result side
// pops with random stalls and checks field by field
module tb_base64_text_decoder;
  import b64d_pkg::*;

  // tracks the decoder state per text and holds the results still owed
  class decode_tracker;
    logic [MaxWidth-1:0]   byte_limit;
    logic [1:0]            grp_pos;
    logic [5:0]            held_six;
    bit                    in_blank_lead;
    bit                    text_done;
    logic [ShownWidth-1:0] byte_total;
    bit                    drop_seen;
    result_t               owed[$];
    int                    mismatches;

    function new();
      byte_limit = MaxOutReset;
      mismatches = 0;
      clear_text();
    endfunction

    function void clear_text();
      grp_pos       = 2'd0;
      held_six      = 6'd0;
      in_blank_lead = 1'b1;
      text_done     = 1'b0;
      byte_total    = '0;
      drop_seen     = 1'b0;
    endfunction

    // sextet of one character, bit 6 set when outside the alphabet
    function logic [6:0] sextet_of(input logic [7:0] c);
      if (c >= 8'h41 && c <= 8'h5A) return 7'(c - 8'h41);
      if (c >= 8'h61 && c <= 8'h7A) return 7'(c - 8'h61 + 8'd26);
      if (c >= 8'h30 && c <= 8'h39) return 7'(c - 8'h30 + 8'd52);
      if (c == CharPlus) return 7'd62;
      if (c == CharSlash) return 7'd63;
      return 7'd64;
    endfunction

    // character that encodes one sextet
    function logic [7:0] char_of(input logic [5:0] s);
      if (s < 6'd26) return 8'h41 + 8'(s);
      if (s < 6'd52) return 8'h61 + 8'(s) - 8'd26;
      if (s < 6'd62) return 8'h30 + 8'(s) - 8'd52;
      if (s == 6'd62) return CharPlus;
      return CharSlash;
    endfunction

    function int outstanding();
      return owed.size();
    endfunction

    // one accepted character request: advance the state, queue what it causes
    function void note_char(input logic [7:0] c, input logic st);
      logic [6:0] sx;
      logic [7:0] b;
      result_t    r;
      if (st) clear_text();
      if (text_done) return;
      if (in_blank_lead && (c == CharSpace || c == CharTab)) return;
      in_blank_lead = 1'b0;
      sx = sextet_of(c);
      if (sx[6]) begin
        // first non-alphabet character closes the text
        text_done    = 1'b1;
        r.kind       = KindEnd;
        r.data_byte  = 8'h00;
        r.byte_count = byte_total;
        r.truncated  = drop_seen;
        owed.push_back(r);
        return;
      end
      case (grp_pos)
        2'd0: begin
          // first of a group only holds its sextet
          held_six = sx[5:0];
          grp_pos  = 2'd1;
          return;
        end
        2'd1: b = {held_six, sx[5:4]};
        2'd2: b = {held_six[3:0], sx[5:2]};
        default: b = {held_six[1:0], sx[5:0]};
      endcase
      held_six = sx[5:0];
      grp_pos  = grp_pos + 2'd1;
      // over the limit: byte dropped, group still advances
      if (byte_total >= byte_limit) begin
        drop_seen = 1'b1;
        return;
      end
      if (byte_total != '1) byte_total = byte_total + 1'b1;
      r.kind       = KindData;
      r.data_byte  = b;
      r.byte_count = byte_total;
      r.truncated  = drop_seen;
      owed.push_back(r);
    endfunction

    task report(input string what);
      if (mismatches < 40) $display("mismatch at %0t: %s", $time, what);
      mismatches++;
    endtask

    // one accepted result request against the oldest owed result
    task check_result(input result_t got);
      result_t want;
      if (owed.size() == 0) begin
        report($sformatf("result with nothing owed, kind %0d byte %02h count %0d",
                         got.kind, got.data_byte, got.byte_count));
        return;
      end
      want = owed.pop_front();
      if (got.kind !== want.kind)
        report($sformatf("kind %0d, wanted %0d", got.kind, want.kind));
      if (got.data_byte !== want.data_byte)
        report($sformatf("data_byte %02h, wanted %02h", got.data_byte, want.data_byte));
      if (got.byte_count !== want.byte_count)
        report($sformatf("byte_count %0d, wanted %0d", got.byte_count, want.byte_count));
      if (got.truncated !== want.truncated)
        report($sformatf("truncated %0d, wanted %0d", got.truncated, want.truncated));
    endtask
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  push;
  logic                  full;
  logic [7:0]            char_code;
  logic                  start_text;
  logic                  empty;
  logic                  pop;
  logic                  kind;
  logic [7:0]            data_byte;
  logic [ShownWidth-1:0] byte_count;
  logic                  truncated;
  logic                  cfg_we;
  logic [MaxWidth-1:0]   cfg_wdata;

  decode_tracker tracker;
  bit            idle_on;
  int            chars_sent;

  base64_text_decoder dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .char_code_i  (char_code),
    .start_text_i (start_text),
    .empty        (empty),
    .pop          (pop),
    .kind_o       (kind),
    .data_byte_o  (data_byte),
    .byte_count_o (byte_count),
    .truncated_o  (truncated),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // watchdog, well past the slowest correct run
  initial begin
    #(64'd18_000_000);
    $display("Simulation FAILED");
    $finish;
  end

  // one character request; push stays high afterwards so back-to-back pushes
  // never lower and raise it in the same step
  task automatic send_char(input logic [7:0] c, input logic st);
    int unsigned gap;
    gap = idle_on ? $urandom_range(0, 12) : 0;
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push       <= 1'b1;
    char_code  <= c;
    start_text <= st;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    tracker.note_char(c, st);
    chars_sent++;
  endtask

  // hold the character side until every owed result has come, then let the
  // pipeline settle past any character that gave no result
  task automatic drain_results();
    push <= 1'b0;
    @(posedge clk_i);
    while (tracker.outstanding() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic write_limit(input logic [MaxWidth-1:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    tracker.byte_limit = v;
  endtask

  // a text with optional leading blanks, random sextets, a terminator of some
  // sort (or none) and a little trailing junk; optionally one corrupted char
  task automatic send_text(input int unsigned n_six, input bit corrupt, input bit pause_mid);
    logic [7:0]  cq[$];
    logic [7:0]  b;
    logic [6:0]  sx;
    int unsigned term;
    int unsigned i;
    repeat ($urandom_range(0, 2)) cq.push_back($urandom_range(0, 1) ? CharSpace : CharTab);
    repeat (n_six) cq.push_back(tracker.char_of(6'($urandom_range(0, 63))));
    if (corrupt && cq.size() > 0)
      cq[$urandom_range(0, cq.size() - 1)] = 8'($urandom_range(0, 255));
    term = $urandom_range(0, 9);
    if (term < 5) begin
      cq.push_back(8'h3D);
    end else if (term == 5) begin
      cq.push_back(8'h00);
    end else if (term < 9) begin
      do begin
        b  = 8'($urandom_range(0, 255));
        sx = tracker.sextet_of(b);
      end while (!sx[6]);
      cq.push_back(b);
    end
    repeat ($urandom_range(0, 2)) cq.push_back(8'($urandom_range(0, 255)));
    for (i = 0; i < cq.size(); i++) begin
      send_char(cq[i], (i == 0) && ($urandom_range(0, 9) != 0));
      if (pause_mid && i == cq.size() / 2) drain_results();
    end
  endtask

  task automatic send_noise();
    repeat ($urandom_range(1, 8))
      send_char(8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0);
  endtask

  // result side: pop with a random stall drawn per result
  initial begin
    int unsigned hold;
    result_t     got;
    hold = 0;
    pop <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (pop && !empty) begin
        got.kind       = kind;
        got.data_byte  = data_byte;
        got.byte_count = byte_count;
        got.truncated  = truncated;
        tracker.check_result(got);
        hold = idle_on ? $urandom_range(0, 12) : 0;
      end
      if (hold > 0) begin
        pop <= 1'b0;
        hold--;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  initial begin
    int unsigned          p;
    int unsigned          pick;
    int unsigned          len;
    int                   rand_target;
    logic [MaxWidth-1:0]  lim;
    tracker    = new();
    idle_on    = 1'b1;
    chars_sent = 0;
    rst_ni     <= 1'b0;
    push       <= 1'b0;
    char_code  <= 8'h00;
    start_text <= 1'b0;
    cfg_we     <= 1'b0;
    cfg_wdata  <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: no start since reset, leading blanks, "Man", both symbols,
    // digits and case extremes, a partial group of three before '='
    send_char(CharSpace, 1'b0);
    send_char(CharTab, 1'b0);
    send_char(8'h54, 1'b0);
    send_char(8'h57, 1'b0);
    send_char(8'h46, 1'b0);
    send_char(8'h75, 1'b0);
    send_char(CharSlash, 1'b0);
    send_char(CharPlus, 1'b0);
    send_char(8'h30, 1'b0);
    send_char(8'h7A, 1'b0);
    send_char(8'h61, 1'b0);
    send_char(8'h5A, 1'b0);
    send_char(8'h41, 1'b0);
    send_char(8'h3D, 1'b0);
    // after end: ignored until the next start
    send_char(8'h51, 1'b0);
    // start on a blank, then nul ends the text behind a lone char
    send_char(CharTab, 1'b1);
    send_char(CharSpace, 1'b0);
    send_char(8'h41, 1'b0);
    send_char(8'h00, 1'b0);
    // start with a top-bit byte: immediate end, nothing delivered
    send_char(8'hFF, 1'b1);
    // blank inside a text ends it
    send_char(8'h51, 1'b1);
    send_char(8'h51, 1'b0);
    send_char(CharSpace, 1'b0);
    // restart halfway through a group
    send_char(CharSlash, 1'b1);
    send_char(CharSlash, 1'b0);
    send_char(8'h3D, 1'b1);

    // random phases, each under its own limit and idling mode
    rand_target = chars_sent + 1475;
    p = 0;
    while (chars_sent < rand_target) begin
      drain_results();
      case (p % 8)
        0: lim = 16'd0;
        1: lim = 16'd1;
        2: lim = 16'd2;
        3: lim = 16'hFFFF;
        4: lim = 16'd3;
        5: lim = 16'($urandom_range(0, 30));
        6: lim = 16'($urandom_range(0, 65535));
        default: lim = 16'd7;
      endcase
      write_limit(lim);
      idle_on = (p % 4) != 3;
      repeat ($urandom_range(4, 10)) begin
        pick = $urandom_range(0, 9);
        len  = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 60) : $urandom_range(0, 16);
        if (pick == 0) send_noise();
        else send_text(len, pick == 1, $urandom_range(0, 5) == 0);
      end
      p++;
    end

    // wind down: everything owed must arrive, then the bench idles before the verdict
    push <= 1'b0;
    @(posedge clk_i);
    while (tracker.outstanding() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (tracker.mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/b64d_pkg.sv
rtl/b64d_fifo.sv
rtl/b64d_front.sv
rtl/b64d_back.sv
rtl/base64_text_decoder.sv
tb/tb_base64_text_decoder.sv
